### rtl/ptmg_pkg.sv
package ptmg_pkg;

    localparam int ROWS       = 28;
    localparam int COLUMNS    = 40;
    localparam int ROW_STRIDE = 64;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 6;
    localparam int IDX_W   = 11;
    localparam int WORD_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int OP_W    = 2;
    localparam int DEPTH   = 256;
    localparam int ADDR_W  = 8;
    localparam int CFG_W   = 16;

    localparam logic [CFG_W-1:0] TILE_BASE_RST  = 16'h0221;
    localparam logic [CFG_W-1:0] TILE_ATTR_RST  = 16'h2000;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_FRAME = 2'd1,
        OP_TILE  = 2'd2
    } t_opcode;

    typedef enum logic {
        CFG_TILE_BASE = 1'b0,
        CFG_TILE_ATTR = 1'b1
    } t_cfg_reg;

    // add d; a sum above 255 loses 255, i.e. wraps one further
    function automatic logic [BYTE_W-1:0] phase_step(
        input logic [BYTE_W-1:0] p,
        input logic [1:0]        d
    );
        logic [BYTE_W:0] v;
        v = {1'b0, p} + {{(BYTE_W-1){1'b0}}, d};
        return v[BYTE_W] ? (v[BYTE_W-1:0] + 8'd1) : v[BYTE_W-1:0];
    endfunction

endpackage

### rtl/ptmg_req_if.sv
interface ptmg_req_if;
    logic                             valid;
    logic                             ready;
    logic [ptmg_pkg::OP_W-1:0]        opcode;
    logic [ptmg_pkg::BYTE_W-1:0]      table_index;
    logic [ptmg_pkg::BYTE_W-1:0]      table_value;

    modport source (output valid, opcode, table_index, table_value, input ready);
    modport sink   (input valid, opcode, table_index, table_value, output ready);
endinterface

### rtl/ptmg_tile_if.sv
interface ptmg_tile_if;
    logic                             valid;
    logic                             ready;
    logic [ptmg_pkg::WORD_W-1:0]      tile_word;
    logic [ptmg_pkg::IDX_W-1:0]       map_index;
    logic                             buffer_select;
    logic                             last_tile;

    modport source (output valid, tile_word, map_index, buffer_select, last_tile,
                    input ready);
    modport sink   (input valid, tile_word, map_index, buffer_select, last_tile,
                    output ready);
endinterface

### rtl/plasma_tile_map_generator.sv
// Plasma tile map generator.
// i_req carries requests: load a wave table byte, start a new frame, or emit
// the next tile. o_tile returns one tile word per emit request while a frame
// is active, in row-major order, with its map position, buffer and last flag.
// i_cfg_* writes tile base (index 0) and attribute bits (index 1); write only
// while the block is idle.
// The read stage registers the table reads for a tile request; the output
// register then registers the sum and drives o_tile.
// Throughput: one request per cycle while o_tile does not stall. Four table
// lookups per tile are served by two copies of the wave table, each read at
// two addresses per cycle. Loads and frame requests give no output.
// When o_tile stalls, the output register and the read stage hold; i_req
// keeps taking requests until both are full, then ready drops.
// Reset clears phases, counters, frame and buffer state and the config
// registers to their defaults; the wave table is not cleared and must be
// loaded before any frame is drawn.
module plasma_tile_map_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ptmg_req_if.sink                      i_req,
    ptmg_tile_if.source                   o_tile,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [ptmg_pkg::CFG_W-1:0]    i_cfg_data
);

    localparam int BW = ptmg_pkg::BYTE_W;

    // two copies of the table, rows on one, columns on the other
    logic [BW-1:0] r_wave_col [ptmg_pkg::DEPTH];
    logic [BW-1:0] r_wave_row [ptmg_pkg::DEPTH];

    logic [ptmg_pkg::CFG_W-1:0] r_tile_base, r_tile_attr;

    logic [BW-1:0] r_fx1, r_fx2, r_fy1, r_fy2;
    logic [BW-1:0] r_rp1, r_rp2, r_cp1, r_cp2;
    logic [ptmg_pkg::ROW_W-1:0] r_row;
    logic [ptmg_pkg::COL_W-1:0] r_col;
    logic r_active, r_flag, r_choice;

    // read stage
    logic                        r_p_valid;
    logic [ptmg_pkg::IDX_W-1:0]  r_p_idx;
    logic                        r_p_buf, r_p_last;
    logic [BW-1:0]               r_rd_c1, r_rd_c2, r_rd_r1, r_rd_r2;

    // output register
    logic                         r_out_valid;
    logic [ptmg_pkg::WORD_W-1:0]  r_out_word;
    logic [ptmg_pkg::IDX_W-1:0]   r_out_idx;
    logic                         r_out_buf, r_out_last;

    logic advance, accept, do_load, do_frame, do_tile, col0, row_end, frame_end;
    logic [BW-1:0] n_rp1, n_rp2, n_cp1, n_cp2, n_fx1, n_fx2, n_fy1, n_fy2;
    logic [BW-1:0] cp1_base, cp2_base;
    logic [ptmg_pkg::IDX_W-1:0] n_idx;
    logic n_last;
    logic [3:0] nib;

    assign advance = !r_out_valid || o_tile.ready;
    assign i_req.ready = !r_p_valid || advance;
    assign accept = i_req.valid && i_req.ready;

    assign do_load  = accept && (i_req.opcode == ptmg_pkg::OP_LOAD);
    assign do_frame = accept && (i_req.opcode == ptmg_pkg::OP_FRAME);
    assign do_tile  = accept && (i_req.opcode == ptmg_pkg::OP_TILE) && r_active;

    assign col0     = (r_col == '0);
    assign n_rp1    = col0 ? ptmg_pkg::phase_step(r_rp1, 2'd1) : r_rp1;
    assign n_rp2    = col0 ? ptmg_pkg::phase_step(r_rp2, 2'd2) : r_rp2;
    assign cp1_base = col0 ? r_fx1 : r_cp1;
    assign cp2_base = col0 ? r_fx2 : r_cp2;
    assign n_cp1    = ptmg_pkg::phase_step(cp1_base, 2'd2);
    assign n_cp2    = ptmg_pkg::phase_step(cp2_base, 2'd3);

    assign n_fx1 = r_fx1 - 8'd3;
    assign n_fy1 = r_fy1 - 8'd3;
    assign n_fx2 = r_fx2 + 8'd2;
    assign n_fy2 = r_fy2 + 8'd1;

    assign n_idx = ptmg_pkg::IDX_W'({5'd0, r_col}
                 + 11'(r_row) * ptmg_pkg::IDX_W'(ptmg_pkg::ROW_STRIDE));
    assign n_last = (r_row >= ptmg_pkg::ROW_W'(ptmg_pkg::ROWS - 1))
                 && (r_col >= ptmg_pkg::COL_W'(ptmg_pkg::COLUMNS - 1));
    assign row_end   = ({1'b0, r_col} + 7'd1) >= 7'(ptmg_pkg::COLUMNS);
    assign frame_end = ({1'b0, r_row} + 6'd1) >= 6'(ptmg_pkg::ROWS);

    // only the low nibble of the four-byte sum is used
    assign nib = r_rd_c1[3:0] + r_rd_c2[3:0] + r_rd_r1[3:0] + r_rd_r2[3:0];

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_wave_col[i_req.table_index] <= i_req.table_value;
            r_wave_row[i_req.table_index] <= i_req.table_value;
        end
        if (do_tile) begin
            r_rd_c1 <= r_wave_col[n_cp1];
            r_rd_c2 <= r_wave_col[n_cp2];
            r_rd_r1 <= r_wave_row[n_rp1];
            r_rd_r2 <= r_wave_row[n_rp2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_base <= ptmg_pkg::TILE_BASE_RST;
            r_tile_attr <= ptmg_pkg::TILE_ATTR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptmg_pkg::CFG_TILE_BASE: r_tile_base <= i_cfg_data;
                ptmg_pkg::CFG_TILE_ATTR: r_tile_attr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fx1 <= '0; r_fx2 <= '0; r_fy1 <= '0; r_fy2 <= '0;
            r_rp1 <= '0; r_rp2 <= '0; r_cp1 <= '0; r_cp2 <= '0;
            r_row <= '0; r_col <= '0;
            r_active <= 1'b0; r_flag <= 1'b0; r_choice <= 1'b0;
        end else if (do_frame) begin
            r_fx1 <= n_fx1; r_fx2 <= n_fx2; r_fy1 <= n_fy1; r_fy2 <= n_fy2;
            r_rp1 <= n_fy1; r_rp2 <= n_fy2;
            r_choice <= r_flag;
            r_flag   <= !r_flag;
            r_row <= '0; r_col <= '0;
            r_active <= 1'b1;
        end else if (do_tile) begin
            r_rp1 <= n_rp1; r_rp2 <= n_rp2; r_cp1 <= n_cp1; r_cp2 <= n_cp2;
            if (row_end) begin
                r_col <= '0;
                if (frame_end) begin
                    r_row <= '0;
                    r_active <= 1'b0;
                end else begin
                    r_row <= r_row + 5'd1;
                end
            end else begin
                r_col <= r_col + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (do_tile) begin
                r_p_valid <= 1'b1;
            end else if (advance) begin
                r_p_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_p_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_tile) begin
            r_p_idx  <= n_idx;
            r_p_buf  <= r_choice;
            r_p_last <= n_last;
        end
        if (advance && r_p_valid) begin
            r_out_word <= (r_tile_base + {12'd0, nib}) | r_tile_attr;
            r_out_idx  <= r_p_idx;
            r_out_buf  <= r_p_buf;
            r_out_last <= r_p_last;
        end
    end

    assign o_tile.valid         = r_out_valid;
    assign o_tile.tile_word     = r_out_word;
    assign o_tile.map_index     = r_out_idx;
    assign o_tile.buffer_select = r_out_buf;
    assign o_tile.last_tile     = r_out_last;

    a_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !advance) |=> (r_p_valid && $stable(r_rd_c1)
            && $stable(r_rd_r2) && $stable(r_p_idx)))
        else $error("read stage lost data while stalled");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tile.valid && o_tile.last_tile) |-> (o_tile.map_index ==
            ptmg_pkg::IDX_W'((ptmg_pkg::ROWS - 1) * ptmg_pkg::ROW_STRIDE
            + ptmg_pkg::COLUMNS - 1)))
        else $error("last tile at wrong map position");

    a_frame_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_frame |=> (r_active && r_row == '0 && r_col == '0 && r_flag != r_choice))
        else $error("frame start did not set up the frame");

    // a request taken with no frame never fills the read stage
    a_no_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !r_active && !do_frame) |=> (!r_p_valid || $past(r_p_valid)))
        else $error("tile emitted with no active frame");

endmodule
